@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define CHK_RUN(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: run-time check failed");

// Property checked at every edge, reset included.
`define CHK_ALL(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("%m: reset check failed");

`endif

@@ rtl/utf8vpl_pkg.sv @@
// Shared types and constants for the UTF-8 valid prefix scanner.
// No dependencies.
package utf8vpl_pkg;

  localparam int MAX_LEN_W = 16;
  localparam int PREFIX_W  = 16;
  localparam int CAUSE_W   = 3;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_TERM  = 3'd0,
    CAUSE_LEAD  = 3'd1,
    CAUSE_LIMIT = 3'd2,
    CAUSE_CONT  = 3'd3,
    CAUSE_RANGE = 3'd4
  } cause_t;

  // Open-sequence tracking state.
  typedef struct packed {
    logic [1:0] bytes_left;
    logic [2:0] seq_size;
    logic [7:0] lead_value;
    logic       range_failed;
    logic       skipping;
  } seq_t;

  // One result word plus its valid flag.
  typedef struct packed {
    logic                vld;
    logic [PREFIX_W-1:0] prefix_length;
    cause_t              stop_cause;
  } res_t;

endpackage

@@ rtl/utf8vpl_step.sv @@
// Per-byte next-state and result logic of the UTF-8 prefix scanner.
// Depends on utf8vpl_pkg.
module utf8vpl_step #(
  parameter int LENGTH_BITS = 16
) (
  input  logic [LENGTH_BITS-1:0]          len_i,
  input  utf8vpl_pkg::seq_t               seq_i,
  input  logic [7:0]                      byte_i,
  input  logic [utf8vpl_pkg::MAX_LEN_W-1:0] max_length_i,
  output logic [LENGTH_BITS-1:0]          len_o,
  output utf8vpl_pkg::seq_t               seq_o,
  output utf8vpl_pkg::res_t               res_o
);
  import utf8vpl_pkg::*;

  localparam int CW = ((LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W) + 1;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] L2_MIN    = 8'hC2;
  localparam logic [7:0] L2_MAX    = 8'hDF;
  localparam logic [7:0] L3_MIN    = 8'hE0;
  localparam logic [7:0] L3_SURR   = 8'hED;
  localparam logic [7:0] L4_MIN    = 8'hF0;
  localparam logic [7:0] L4_MAX    = 8'hF4;
  localparam logic [7:0] B_A0      = 8'hA0;
  localparam logic [7:0] B_9F      = 8'h9F;
  localparam logic [7:0] B_90      = 8'h90;
  localparam logic [7:0] B_8F      = 8'h8F;

  logic [CW-1:0]          cap_ext;
  logic [CW-1:0]          max_ext;
  logic [CW-1:0]          limit_ext;
  logic [CW-1:0]          len_ext;
  logic [CW-1:0]          need_ext;
  logic [2:0]             lead_size;
  logic                   second_ok;
  logic                   rf_nxt;
  logic [1:0]             br_dec;
  logic [LENGTH_BITS-1:0] len_seq;
  logic [LENGTH_BITS-1:0] len_one;

  assign cap_ext   = (CW'(1) << LENGTH_BITS) - CW'(1);
  assign max_ext   = CW'(max_length_i);
  assign limit_ext = (max_ext < cap_ext) ? max_ext : cap_ext;
  assign len_ext   = CW'(len_i);
  assign need_ext  = len_ext + CW'(lead_size);
  assign len_seq   = len_i + LENGTH_BITS'(seq_i.seq_size);
  assign len_one   = len_i + LENGTH_BITS'(1);
  assign br_dec    = seq_i.bytes_left - 2'd1;

  always_comb begin
    if (byte_i <= ASCII_MAX) begin
      lead_size = 3'd1;
    end else if (byte_i >= L2_MIN && byte_i <= L2_MAX) begin
      lead_size = 3'd2;
    end else if (byte_i >= L3_MIN && byte_i < L4_MIN) begin
      lead_size = 3'd3;
    end else if (byte_i >= L4_MIN && byte_i <= L4_MAX) begin
      lead_size = 3'd4;
    end else begin
      lead_size = 3'd0;
    end
  end

  always_comb begin
    unique case (seq_i.lead_value)
      L3_MIN:  second_ok = (byte_i >= B_A0);
      L3_SURR: second_ok = (byte_i <= B_9F);
      L4_MIN:  second_ok = (byte_i >= B_90);
      L4_MAX:  second_ok = (byte_i <= B_8F);
      default: second_ok = 1'b1;
    endcase
  end

  assign rf_nxt = seq_i.range_failed |
                  ((({1'b0, seq_i.bytes_left} + 3'd1) == seq_i.seq_size) & ~second_ok);

  always_comb begin
    len_o               = len_i;
    seq_o               = seq_i;
    res_o.vld           = 1'b0;
    res_o.prefix_length = len_ext[PREFIX_W-1:0];
    res_o.stop_cause    = CAUSE_TERM;
    if (seq_i.skipping) begin
      if (byte_i == 8'd0) begin
        len_o = '0;
        seq_o = '0;
      end
    end else if (seq_i.bytes_left != 2'd0) begin
      if (byte_i == 8'd0) begin
        res_o.vld        = 1'b1;
        res_o.stop_cause = CAUSE_CONT;
        len_o            = '0;
        seq_o            = '0;
      end else if ((byte_i & CONT_MASK) != CONT_TAG) begin
        res_o.vld        = 1'b1;
        res_o.stop_cause = CAUSE_CONT;
        seq_o.skipping   = 1'b1;
        seq_o.bytes_left = 2'd0;
      end else begin
        seq_o.bytes_left = br_dec;
        if (br_dec == 2'd0) begin
          if (rf_nxt) begin
            res_o.vld          = 1'b1;
            res_o.stop_cause   = CAUSE_RANGE;
            seq_o.skipping     = 1'b1;
            seq_o.range_failed = 1'b0;
          end else begin
            len_o = len_seq;
          end
        end else begin
          seq_o.range_failed = rf_nxt;
        end
      end
    end else if (byte_i == 8'd0) begin
      res_o.vld        = 1'b1;
      res_o.stop_cause = CAUSE_TERM;
      len_o            = '0;
      seq_o            = '0;
    end else if (lead_size == 3'd0) begin
      res_o.vld        = 1'b1;
      res_o.stop_cause = CAUSE_LEAD;
      seq_o.skipping   = 1'b1;
    end else if (need_ext > limit_ext) begin
      res_o.vld        = 1'b1;
      res_o.stop_cause = CAUSE_LIMIT;
      seq_o.skipping   = 1'b1;
    end else if (lead_size == 3'd1) begin
      len_o = len_one;
    end else begin
      seq_o.seq_size     = lead_size;
      seq_o.bytes_left   = lead_size[1:0] - 2'd1;
      seq_o.lead_value   = byte_i;
      seq_o.range_failed = 1'b0;
    end
  end

endmodule

@@ rtl/utf8vpl_obuf.sv @@
// Two-entry result buffer (output register plus skid word).
// Depends on utf8vpl_pkg.
module utf8vpl_obuf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  utf8vpl_pkg::res_t                   push_i,
  output logic                                full_o,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [utf8vpl_pkg::PREFIX_W-1:0]    out_prefix_length,
  output logic [utf8vpl_pkg::CAUSE_W-1:0]     out_stop_cause
);
  import utf8vpl_pkg::*;

  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop = head_r.vld & out_ready;

  always_comb begin
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (!head_r.vld || pop) begin
      head_nxt     = skid_r.vld ? skid_r : push_i;
      head_nxt.vld = skid_r.vld | push_i.vld;
      skid_nxt     = push_i;
      skid_nxt.vld = skid_r.vld & push_i.vld;
    end else if (push_i.vld) begin
      skid_nxt = push_i;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      head_r.vld <= 1'b0;
      skid_r.vld <= 1'b0;
    end
  end

  assign full_o            = skid_r.vld;
  assign out_valid         = head_r.vld;
  assign out_prefix_length = head_r.prefix_length;
  assign out_stop_cause    = head_r.stop_cause;

endmodule

@@ rtl/utf8_valid_prefix_length.sv @@
// UTF-8 valid prefix scanner, top level: input word register, scan state, result buffer.
// Depends on utf8vpl_pkg, utf8vpl_step and utf8vpl_obuf.
// Each text byte is held in the input register; its result word is then registered in the result buffer.
// Throughput: one text byte per cycle; the input register stalls only while both
// result slots are held by the consumer.
// Reset (synchronous, active low): scan state cleared, buffers empty, max_length = 65535.
module utf8_valid_prefix_length #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_prefix_length,
  output logic [2:0]  out_stop_cause
);
  import utf8vpl_pkg::*;

  logic [7:0]             byte_r;
  logic                   byte_vld_r, byte_vld_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  seq_t                   seq_r, seq_nxt;
  logic [MAX_LEN_W-1:0]   max_length_r;
  res_t                   res;
  res_t                   push;
  logic                   full;
  logic                   advance;
  logic                   in_acc;

  assign advance      = byte_vld_r & ~full;
  assign in_ready     = ~byte_vld_r | advance;
  assign in_acc       = in_valid & in_ready;
  assign byte_vld_nxt = in_acc | (byte_vld_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      len_r        <= '0;
      seq_r        <= '0;
      max_length_r <= MAX_LEN_RESET;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      if (advance) begin
        len_r <= len_nxt;
        seq_r <= seq_nxt;
      end
      if (cfg_we) begin
        max_length_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_text_byte;
    end
  end

  utf8vpl_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .len_i        (len_r),
    .seq_i        (seq_r),
    .byte_i       (byte_r),
    .max_length_i (max_length_r),
    .len_o        (len_nxt),
    .seq_o        (seq_nxt),
    .res_o        (res)
  );

  always_comb begin
    push     = res;
    push.vld = res.vld & advance;
  end

  utf8vpl_obuf u_obuf (
    .clk               (clk),
    .rst_n             (rst_n),
    .push_i            (push),
    .full_o            (full),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_prefix_length (out_prefix_length),
    .out_stop_cause    (out_stop_cause)
  );

endmodule

@@ rtl/utf8vpl_checker.sv @@
// Port-level checks for the UTF-8 prefix scanner, bound to the top level.
// Depends on utf8vpl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8vpl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_prefix_length,
  input logic [2:0]  out_stop_cause
);
  import utf8vpl_pkg::*;

  logic [18:0] out_word;

  assign out_word = {out_prefix_length, out_stop_cause};

  `CHK_ALL(a_rst_out_empty, !rst_n |=> !out_valid)
  `CHK_ALL(a_rst_in_ready, !rst_n |=> in_ready)
  `CHK_RUN(a_cause_known, out_valid |-> out_stop_cause <= CAUSE_RANGE)
  `CHK_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word))

endmodule

bind utf8_valid_prefix_length utf8vpl_checker u_chk (.*);

@@ sim/utf8_valid_prefix_length_check.sv @@
// Checker for the UTF-8 valid prefix scanner: watches the config port and both channels,
// predicts each result word and compares it with the block's output.
// Depends on utf8vpl_pkg.
module utf8_valid_prefix_length_check (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [utf8vpl_pkg::MAX_LEN_W-1:0] cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [7:0]                        in_text_byte,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [utf8vpl_pkg::PREFIX_W-1:0]  out_prefix_length,
  input  logic [utf8vpl_pkg::CAUSE_W-1:0]   out_stop_cause,
  output int                                pending,
  output int                                fail_count
);
  import utf8vpl_pkg::*;

  typedef struct packed {
    logic [PREFIX_W-1:0] len;
    cause_t              cause;
  } prefix_result_t;

  prefix_result_t        expected_results[$];
  logic [MAX_LEN_W-1:0]  max_len;
  logic [PREFIX_W-1:0]   length_so_far;
  logic [1:0]            cont_left;
  logic [2:0]            seq_len;
  logic [7:0]            lead_byte;
  logic                  range_bad;
  logic                  skip_mode;
  int                    errors = 0;

  assign fail_count = errors;

  task automatic restart();
    length_so_far = '0;
    cont_left     = 2'd0;
    seq_len       = 3'd0;
    lead_byte     = 8'h00;
    range_bad     = 1'b0;
    skip_mode     = 1'b0;
  endtask

  task automatic emit(input cause_t cause);
    prefix_result_t r;
    r.len   = length_so_far;
    r.cause = cause;
    expected_results.push_back(r);
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    case (lead)
      8'hE0:   return b >= 8'hA0;
      8'hED:   return b <= 8'h9F;
      8'hF0:   return b >= 8'h90;
      8'hF4:   return b <= 8'h8F;
      default: return 1'b1;
    endcase
  endfunction

  task automatic scan_byte(input logic [7:0] b);
    logic [2:0] size;
    size = 3'd0;
    if (skip_mode) begin
      if (b == 8'h00) restart();
    end else if (cont_left != 2'd0) begin
      if (b == 8'h00) begin
        emit(CAUSE_CONT);
        restart();
      end else if (b[7:6] != 2'b10) begin
        emit(CAUSE_CONT);
        skip_mode = 1'b1;
        cont_left = 2'd0;
      end else begin
        if ({1'b0, cont_left} + 3'd1 == seq_len && !second_ok(lead_byte, b)) range_bad = 1'b1;
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          if (range_bad) begin
            emit(CAUSE_RANGE);
            skip_mode = 1'b1;
            range_bad = 1'b0;
          end else begin
            length_so_far = length_so_far + PREFIX_W'(seq_len);
          end
        end
      end
    end else if (b == 8'h00) begin
      emit(CAUSE_TERM);
      restart();
    end else begin
      if (b <= 8'h7F) size = 3'd1;
      else if (b >= 8'hC2 && b <= 8'hDF) size = 3'd2;
      else if (b >= 8'hE0 && b <= 8'hEF) size = 3'd3;
      else if (b >= 8'hF0 && b <= 8'hF4) size = 3'd4;
      if (size == 3'd0) begin
        emit(CAUSE_LEAD);
        skip_mode = 1'b1;
      end else if ({1'b0, length_so_far} + 17'(size) > {1'b0, max_len}) begin
        emit(CAUSE_LIMIT);
        skip_mode = 1'b1;
      end else if (size == 3'd1) begin
        length_so_far = length_so_far + 16'd1;
      end else begin
        seq_len   = size;
        cont_left = 2'(size - 3'd1);
        lead_byte = b;
        range_bad = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    prefix_result_t want;
    if (!rst_n) begin
      max_len = MAX_LEN_RESET;
      restart();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          log_error($sformatf("unexpected result word: len %0d cause %0d",
                              out_prefix_length, out_stop_cause));
        end else begin
          want = expected_results.pop_front();
          if (out_prefix_length !== want.len || out_stop_cause !== want.cause)
            log_error($sformatf("result mismatch: expected len %0d cause %0d, got len %0d cause %0d",
                                want.len, want.cause, out_prefix_length, out_stop_cause));
        end
      end
      if (in_valid && in_ready) scan_byte(in_text_byte);
      if (cfg_we) max_len = cfg_wdata;
    end
    pending <= expected_results.size();
  end

endmodule

@@ sim/utf8_valid_prefix_length_test.sv @@
// Testbench top for utf8_valid_prefix_length: clock, reset, text stimulus, limit phases
// and the verdict. Depends on utf8vpl_pkg, the block and utf8_valid_prefix_length_check.
module utf8_valid_prefix_length_test;
  import utf8vpl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 195;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [MAX_LEN_W-1:0] cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_text_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [PREFIX_W-1:0]  out_prefix_length;
  logic [CAUSE_W-1:0]   out_stop_cause;

  int         pending;
  int         fail_count;
  int         idle_pct   = 18;
  int         stall_pct  = 18;
  int         cycles     = 0;
  int         sent_bytes = 0;
  logic [7:0] text_q[$];

  utf8_valid_prefix_length i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_prefix_length(out_prefix_length),
    .out_stop_cause   (out_stop_cause)
  );

  utf8_valid_prefix_length_check i_prefix_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_prefix_length(out_prefix_length),
    .out_stop_cause   (out_stop_cause),
    .pending          (pending),
    .fail_count       (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range('h80, 'hBF));
  endfunction

  function automatic logic [7:0] non_cont_byte();
    return $urandom_range(0, 1) ? 8'($urandom_range(1, 'h7F)) : 8'($urandom_range('hC0, 'hFF));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i]);
    text_q.delete();
  endtask

  task automatic add_valid_char(input int min_size);
    logic [7:0] lead;
    case ($urandom_range(min_size, 4))
      1: text_q.push_back(8'($urandom_range(1, 'h7F)));
      2: begin
        text_q.push_back(8'($urandom_range('hC2, 'hDF)));
        text_q.push_back(cont_byte());
      end
      3: begin
        lead = 8'($urandom_range('hE0, 'hEF));
        text_q.push_back(lead);
        if (lead == 8'hE0) text_q.push_back(8'($urandom_range('hA0, 'hBF)));
        else if (lead == 8'hED) text_q.push_back(8'($urandom_range('h80, 'h9F)));
        else text_q.push_back(cont_byte());
        text_q.push_back(cont_byte());
      end
      default: begin
        lead = 8'($urandom_range('hF0, 'hF4));
        text_q.push_back(lead);
        if (lead == 8'hF0) text_q.push_back(8'($urandom_range('h90, 'hBF)));
        else if (lead == 8'hF4) text_q.push_back(8'($urandom_range('h80, 'h8F)));
        else text_q.push_back(cont_byte());
        text_q.push_back(cont_byte());
        text_q.push_back(cont_byte());
      end
    endcase
  endtask

  // Appends one broken sequence or a random byte; done is set when it already ends the string.
  task automatic add_fault(output bit done);
    int kind;
    int start;
    int keep;
    done = 1'b0;
    kind = $urandom_range(0, 5);
    case (kind)
      0: text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                               : 8'($urandom_range('hF5, 'hFF)));
      1, 2: begin
        start = text_q.size();
        add_valid_char(2);
        keep = $urandom_range(1, text_q.size() - start - 1);
        while (text_q.size() > start + keep) void'(text_q.pop_back());
        if (kind == 1) begin
          text_q.push_back(non_cont_byte());
        end else begin
          text_q.push_back(8'h00);
          done = 1'b1;
        end
      end
      3: begin
        case ($urandom_range(0, 3))
          0: begin
            text_q.push_back(8'hE0);
            text_q.push_back(8'($urandom_range('h80, 'h9F)));
          end
          1: begin
            text_q.push_back(8'hED);
            text_q.push_back(8'($urandom_range('hA0, 'hBF)));
          end
          2: begin
            text_q.push_back(8'hF0);
            text_q.push_back(8'($urandom_range('h80, 'h8F)));
            text_q.push_back(cont_byte());
          end
          default: begin
            text_q.push_back(8'hF4);
            text_q.push_back(8'($urandom_range('h90, 'hBF)));
            text_q.push_back(cont_byte());
          end
        endcase
        text_q.push_back(cont_byte());
      end
      4: begin
        // range broken on the second byte, then a bad or missing continuation
        text_q.push_back(8'hF4);
        text_q.push_back(8'($urandom_range('h90, 'hBF)));
        if ($urandom_range(0, 1)) text_q.push_back(cont_byte());
        if ($urandom_range(0, 1)) begin
          text_q.push_back(8'h00);
          done = 1'b1;
        end else begin
          text_q.push_back(non_cont_byte());
        end
      end
      default: text_q.push_back(8'($urandom_range(1, 255)));
    endcase
    if (!done) repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic build_string();
    int n;
    bit done;
    done = 1'b0;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(0, 8);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      repeat (n) add_valid_char(1);
      if ($urandom_range(99) < 30) add_fault(done);
    end
    if (!done) text_q.push_back(8'h00);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [MAX_LEN_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [MAX_LEN_W-1:0] limits[7];
    int start;
    limits = '{16'hFFFF, 16'd0, 16'd1, 16'd4, MAX_LEN_W'($urandom_range(2, 40)),
               MAX_LEN_W'($urandom_range(5, 200)), 16'hFFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_max_length(MAX_LEN_RESET);

    text_q = '{8'h00};                                 send_text();
    text_q = '{8'h7F, 8'h00};                          send_text();
    text_q = '{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'h00};     send_text();
    text_q = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'h00};     send_text();
    text_q = '{8'hFF, 8'h41, 8'h00};                   send_text();
    text_q = '{8'hE0, 8'h9F, 8'h80, 8'h00};            send_text();
    text_q = '{8'hF4, 8'h90, 8'h41, 8'h00};            send_text();
    text_q = '{8'hE1, 8'h80, 8'h00};                   send_text();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      set_max_length(limits[p]);
      start = sent_bytes;
      while (sent_bytes - start < PHASE_BYTES) begin
        build_string();
        send_text();
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
